// ===== design/obstacle_speed_limiter_unit_defines.svh =====
// Assertion macros used by the speed limiter top level.
// Files that check their own logic take this header by include.
`ifndef OBSTACLE_SPEED_LIMITER_UNIT_DEFINES_SVH
`define OBSTACLE_SPEED_LIMITER_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off during reset.
`define OSL_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off during reset.
`define OSL_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/osl_pkg.sv =====
// Package for the obstacle speed limiter: widths, codes and the tangent table.
// Used by osl_serdiv and obstacle_speed_limiter_unit.
package osl_pkg;

  localparam int VelW   = 16;
  localparam int DistW  = 16;
  localparam int BeamW  = 9;
  localparam int ZoneW  = 2;
  localparam int NumBeams = 512;
  localparam int BeamAw = $clog2(NumBeams);
  localparam int AngW   = 7;
  localparam int TanW   = 32;

  localparam logic FuncLoad  = 1'b0;
  localparam logic FuncQuery = 1'b1;

  localparam logic [ZoneW-1:0] ZoneClear = 2'd0;
  localparam logic [ZoneW-1:0] ZoneScale = 2'd1;
  localparam logic [ZoneW-1:0] ZoneStop  = 2'd2;
  localparam logic [ZoneW-1:0] ZoneRsvd  = 2'd3;

  localparam logic CfgMaxDist = 1'b0;
  localparam logic CfgMinDist = 1'b1;

  localparam logic [DistW-1:0] MaxDistRst = 16'd1000;
  localparam logic [DistW-1:0] MinDistRst = 16'd200;

  typedef logic [TanW-1:0] tan_t [0:89];

  // Build tan(k deg) in Q24 from truncated Taylor series in Q30.
  function automatic tan_t build_tan();
    tan_t        t;
    logic [63:0] rad;
    logic [63:0] x2;
    logic [63:0] ts;
    logic [63:0] tc;
    longint      s;
    longint      c;
    t[0] = '0;
    for (int k = 1; k < 90; k++) begin
      rad = (64'(k) * 64'd3373259426 + 64'd90) / 64'd180;
      x2  = (rad * rad) >> 30;
      s   = longint'(rad);
      c   = longint'(64'd1 << 30);
      ts  = rad;
      tc  = 64'd1 << 30;
      for (int n = 1; n <= 12; n++) begin
        ts = ((ts * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
        tc = ((tc * x2) >> 30) / 64'((2 * n - 1) * (2 * n));
        if ((n % 2) == 1) begin
          s = s - longint'(ts);
          c = c - longint'(tc);
        end else begin
          s = s + longint'(ts);
          c = c + longint'(tc);
        end
      end
      if (c <= 0) c = 1;
      if (s < 0) s = 0;
      t[k] = TanW'(((64'(s) << 24) + 64'(c) / 64'd2) / 64'(c));
    end
    t[45] = TanW'(64'd1 << 24);
    return t;
  endfunction

  localparam tan_t TanQ24 = build_tan();

endpackage

// ===== design/osl_serdiv.sv =====
// Bit-serial restoring divider: one quotient bit per cycle.
// Needs osl_pkg; the dividend's upper half must be below the divisor.
module osl_serdiv (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [2*osl_pkg::VelW-1:0] dividend_i,
  input  logic [osl_pkg::DistW-1:0]  divisor_i,
  output logic                       done_o,
  output logic [osl_pkg::VelW-1:0]   quot_o
);
  import osl_pkg::*;

  localparam int CntW = $clog2(VelW);

  logic [DistW-1:0] rem_q, rem_d;
  logic [VelW-1:0]  sh_q, sh_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [DistW:0]   trial;

  // Shift one dividend bit into the remainder and try the subtract
  always_comb begin
    trial  = {rem_q, sh_q[VelW-1]};
    rem_d  = rem_q;
    sh_d   = sh_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d  = dividend_i[2*VelW-1:VelW];
      sh_d   = dividend_i[VelW-1:0];
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial >= {1'b0, divisor_i}) begin
        rem_d = DistW'(trial - {1'b0, divisor_i});
        sh_d  = {sh_q[VelW-2:0], 1'b1};
      end else begin
        rem_d = trial[DistW-1:0];
        sh_d  = {sh_q[VelW-2:0], 1'b0};
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CntW'(VelW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Hold control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Advance the datapath
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    sh_q  <= sh_d;
  end

  assign done_o = done_q;
  assign quot_o = sh_q;

endmodule

// ===== design/obstacle_speed_limiter_unit.sv =====
// Obstacle speed limiter top level: beam store, angle search, limiting.
// Needs osl_pkg, osl_serdiv and obstacle_speed_limiter_unit_defines.svh.
//
// Input channel (in_valid_i / in_stall_o) carries load and query requests.
// A load (func 0) writes range_mm into the beam store in the accept cycle
// and gives no result; the input stays open for the next request in the next cycle.
// A query (func 1) gives one result on the output channel (out_valid_o /
// out_stall_i) with the limited velocity and the zone code.
// A query runs a 7-step binary search over the tangent table (one 16x32
// multiply and compare per step; skipped when vel_x is zero), reads the
// store (StRd), classifies the range (StLim), multiplies (StMul) and runs
// the bit-serial dividers, which work on both velocity parts together. Clear
// and stop zones skip the dividers. One query is worked at a time.
// After reset the store is cleared, one entry per cycle; requests stall
// meanwhile, and configuration writes are taken at any time.
// A result waits in the output register while out_stall_i is high; the
// input side keeps taking loads, and a finished query waits for the
// output register to free up.
`include "obstacle_speed_limiter_unit_defines.svh"

module obstacle_speed_limiter_unit (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic                      cfg_idx_i,
  input  logic [osl_pkg::DistW-1:0] cfg_wdata_i,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic                      func_i,
  input  logic [osl_pkg::BeamW-1:0] beam_index_i,
  input  logic [osl_pkg::DistW-1:0] range_mm_i,
  input  logic signed [osl_pkg::VelW-1:0] vel_x_i,
  input  logic signed [osl_pkg::VelW-1:0] vel_y_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic signed [osl_pkg::VelW-1:0] new_x_o,
  output logic signed [osl_pkg::VelW-1:0] new_y_o,
  output logic [osl_pkg::ZoneW-1:0] zone_o
);
  import osl_pkg::*;

  localparam logic [2:0] StClr  = 3'd0;
  localparam logic [2:0] StIdle = 3'd1;
  localparam logic [2:0] StSrch = 3'd2;
  localparam logic [2:0] StRd   = 3'd3;
  localparam logic [2:0] StLim  = 3'd4;
  localparam logic [2:0] StMul  = 3'd5;
  localparam logic [2:0] StDiv  = 3'd6;
  localparam logic [2:0] StDone = 3'd7;

  localparam logic [AngW-1:0] AngMax = 7'd89;
  localparam logic [AngW-1:0] AngRight = 7'd90;

  logic [2:0]        state_q, state_d;
  logic [DistW-1:0]  max_q, min_q;
  logic [BeamAw-1:0] clr_q;
  logic [2:0]        bit_q, bit_d;
  logic [AngW-1:0]   ang_q, ang_d;
  logic [VelW-1:0]   ax_q, ay_q;
  logic              xneg_q, yneg_q;
  logic signed [VelW-1:0] vx_q, vy_q;
  logic [DistW-1:0]  num_q, den_q;
  logic [ZoneW-1:0]  zn_q;
  logic              ovld_q;
  logic signed [VelW-1:0] ox_q, oy_q;
  logic [ZoneW-1:0]  oz_q;

  logic [DistW-1:0]  mem [0:NumBeams-1];
  logic [DistW-1:0]  rdata_q;
  logic [BeamAw-1:0] raddr;
  logic              wen;
  logic [BeamAw-1:0] waddr;
  logic [DistW-1:0]  wdata;

  logic              in_acc;
  logic              out_acc;
  logic [AngW-1:0]   cand;
  logic [AngW-1:0]   tab_idx;
  logic [47:0]       lhs, rhs;
  logic [8:0]        dir;
  logic              dx_done, dy_done;
  logic [VelW-1:0]   qx, qy;
  logic              div_start;
  logic signed [VelW-1:0] rx, ry;

  assign in_acc  = in_valid_i && !in_stall_o;
  assign out_acc = ovld_q && !out_stall_i;
  assign in_stall_o = (state_q != StIdle);

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q <= MaxDistRst;
      min_q <= MinDistRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgMaxDist: max_q <= cfg_wdata_i;
        CfgMinDist: min_q <= cfg_wdata_i;
        default:    max_q <= max_q;
      endcase
    end
  end

  // One search step: test the next angle bit against the tangent table
  assign cand    = ang_q | AngW'(1 << bit_q);
  assign tab_idx = (cand > AngMax) ? AngMax : cand;
  assign lhs     = {8'd0, ay_q, 24'd0};
  assign rhs     = ax_q * TanQ24[tab_idx];

  // Map the angle into the quadrant
  always_comb begin
    priority if (!xneg_q && !yneg_q) dir = 9'd180 - 9'(ang_q);
    else if (!xneg_q)                dir = 9'd180 + 9'(ang_q);
    else if (!yneg_q)                dir = 9'(ang_q);
    else                             dir = 9'd360 - 9'(ang_q);
  end
  assign raddr = BeamAw'(dir);

  // Store write: clearing pass or load request
  always_comb begin
    wen   = 1'b0;
    waddr = clr_q;
    wdata = '0;
    if (state_q == StClr) begin
      wen = 1'b1;
    end else if (in_acc && func_i == FuncLoad && 32'(beam_index_i) < NumBeams) begin
      wen   = 1'b1;
      waddr = BeamAw'(beam_index_i);
      wdata = range_mm_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wen) mem[waddr] <= wdata;
    rdata_q <= mem[raddr];
  end

  // Sequencer
  always_comb begin
    state_d   = state_q;
    bit_d     = bit_q;
    ang_d     = ang_q;
    div_start = 1'b0;
    unique case (state_q)
      StClr: begin
        if (clr_q == BeamAw'(NumBeams - 1)) state_d = StIdle;
      end
      StIdle: begin
        if (in_acc && func_i == FuncQuery) begin
          bit_d = 3'd6;
          if (vel_x_i == '0) begin
            ang_d   = AngRight;
            state_d = StRd;
          end else begin
            ang_d   = '0;
            state_d = StSrch;
          end
        end
      end
      StSrch: begin
        if (cand <= AngMax && lhs >= rhs) ang_d = cand;
        bit_d = bit_q - 1'b1;
        if (bit_q == 3'd0) state_d = StRd;
      end
      StRd:  state_d = StLim;
      StLim: state_d = StMul;
      StMul: begin
        if (zn_q == ZoneScale) begin
          div_start = 1'b1;
          state_d   = StDiv;
        end else begin
          state_d = StDone;
        end
      end
      StDiv: if (dx_done) state_d = StDone;
      StDone: if (!ovld_q || out_acc) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StClr;
      clr_q   <= '0;
      bit_q   <= '0;
      ang_q   <= '0;
    end else begin
      state_q <= state_d;
      bit_q   <= bit_d;
      ang_q   <= ang_d;
      if (state_q == StClr) clr_q <= clr_q + 1'b1;
    end
  end

  // Capture the query velocity
  always_ff @(posedge clk_i) begin
    if (in_acc && func_i == FuncQuery) begin
      vx_q   <= vel_x_i;
      vy_q   <= vel_y_i;
      xneg_q <= vel_x_i[VelW-1];
      yneg_q <= vel_y_i[VelW-1];
      ax_q   <= vel_x_i[VelW-1] ? VelW'(-vel_x_i) : VelW'(vel_x_i);
      ay_q   <= vel_y_i[VelW-1] ? VelW'(-vel_y_i) : VelW'(vel_y_i);
    end
  end

  // Classify the beam range once the read data has arrived
  always_ff @(posedge clk_i) begin
    if (state_q == StLim) begin
      priority if (rdata_q >= max_q) zn_q <= ZoneClear;
      else if (rdata_q > min_q)      zn_q <= ZoneScale;
      else                           zn_q <= ZoneStop;
      num_q <= rdata_q - min_q;
      den_q <= max_q - min_q;
    end
  end

  osl_serdiv u_div_x (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (ax_q * num_q),
    .divisor_i  (den_q),
    .done_o     (dx_done),
    .quot_o     (qx)
  );

  osl_serdiv u_div_y (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (ay_q * num_q),
    .divisor_i  (den_q),
    .done_o     (dy_done),
    .quot_o     (qy)
  );

  // Form the limited velocity
  always_comb begin
    unique case (zn_q)
      ZoneClear: begin
        rx = vx_q;
        ry = vy_q;
      end
      ZoneScale: begin
        rx = xneg_q ? -$signed(qx) : $signed(qx);
        ry = yneg_q ? -$signed(qy) : $signed(qy);
      end
      default: begin
        rx = '0;
        ry = '0;
      end
    endcase
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovld_q <= 1'b0;
    end else if (state_q == StDone && (!ovld_q || out_acc)) begin
      ovld_q <= 1'b1;
    end else if (out_acc) begin
      ovld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == StDone && (!ovld_q || out_acc)) begin
      ox_q <= rx;
      oy_q <= ry;
      oz_q <= zn_q;
    end
  end

  assign out_valid_o = ovld_q;
  assign new_x_o     = ox_q;
  assign new_y_o     = oy_q;
  assign zone_o      = oz_q;

  `OSL_ASSERT_IMP(a_zone_legal, out_valid_o, zone_o != ZoneRsvd, "reserved zone code")
  `OSL_ASSERT_IMP(a_stop_zero, out_valid_o && zone_o == ZoneStop, new_x_o == '0 && new_y_o == '0, "stop zone with motion")
  `OSL_ASSERT_NXT(a_query_go, in_acc && func_i == FuncQuery, state_q == StSrch || state_q == StRd, "query not started")
  `OSL_ASSERT_IMP(a_div_pair, state_q == StDiv, dx_done == dy_done, "dividers out of step")

endmodule
